// ----- rtl/core/gsa_pkg.sv -----
// Package for the generational slot allocator: opcodes, status codes,
// field widths and the packed transfer types of the input and result channels.
// No dependencies.
package gsa_pkg;

  localparam int unsigned OpW         = 2;
  localparam int unsigned SlotFieldW  = 24;
  localparam int unsigned HandleW     = 56;
  localparam int unsigned HandleGenW  = HandleW - SlotFieldW;
  localparam int unsigned GivenSlotW  = 10;
  localparam int unsigned GivenGenW   = 32;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned UsedCountW  = 11;

  typedef enum logic [OpW-1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CHECK   = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK          = 2'd0,
    ST_POOL_EMPTY  = 2'd1,
    ST_OUT_OF_RANGE = 2'd2,
    ST_DOUBLE_FREE = 2'd3
  } status_e;

  typedef struct packed {
    op_e                   op;
    logic [SlotFieldW-1:0] slot;
    logic [HandleW-1:0]    handle;
  } in_item_t;

  typedef struct packed {
    logic [GivenSlotW-1:0] given_slot;
    logic [GivenGenW-1:0]  given_generation;
    status_e               status;
    logic                  handle_live;
    logic [UsedCountW-1:0] used_count;
  } out_item_t;

endpackage

// ----- rtl/core/generational_slot_allocator.sv -----
// Generational slot allocator: LIFO free stack and per-slot generation memory.
// Uses gsa_pkg for the opcodes, status codes and channel transfer types.
// Reads are registered at the transfer, the result when the output is free.
// Throughput: one item per cycle while results are taken; the next item's
// memory read overlaps the previous item's write-back, so one port pair per
// memory sets the rate. Reset: no clearing pass; ready as soon as reset ends.
module generational_slot_allocator #(
  parameter int unsigned SLOT_COUNT = 1024,
  parameter int unsigned GEN_BITS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gsa_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gsa_pkg::out_item_t  out_item_o
);

  // Slot index width, width of the stack pointer (it can hold SLOT_COUNT itself)
  // and the width used to compare a stored generation with a handle's.
  localparam int unsigned SlotW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned TopW   = $clog2(SLOT_COUNT + 1);
  localparam int unsigned CmpW   = (GEN_BITS > gsa_pkg::HandleGenW) ?
                                   GEN_BITS : gsa_pkg::HandleGenW;
  localparam int unsigned StkW   = SlotW + GEN_BITS;
  localparam int unsigned SltW   = GEN_BITS + 1;
  localparam int unsigned RangeW = gsa_pkg::SlotFieldW + 1;

  localparam logic [TopW-1:0]   SlotCountT = TopW'(SLOT_COUNT);
  localparam logic [RangeW-1:0] SlotCountR = RangeW'(SLOT_COUNT);

  // The free stack holds {slot, generation} pairs, so an acquire learns the
  // slot's current generation without a second memory read. The slot memory
  // holds {allocated mark, generation} for each slot.
  logic [StkW-1:0] stk_mem [SLOT_COUNT];
  logic [SltW-1:0] slt_mem [SLOT_COUNT];

  // Neither memory is cleared at reset. Instead, min_top_q records the lowest
  // stack pointer ever reached. Stack entries below it were never written and
  // are decoded as if they held (slot SLOT_COUNT - 1 - index, generation
  // zero). Slots at or above SLOT_COUNT - min_top_q have never been handed
  // out, so they were never written and read as unallocated, generation zero.
  logic [TopW-1:0] top_q, top_d;
  logic [TopW-1:0] min_top_q, min_top_d;

  logic                  busy_q;
  gsa_pkg::op_e          op_q;
  logic [SlotW-1:0]      addr_q;
  logic                  range_ok_q;
  logic [gsa_pkg::HandleGenW-1:0] hgen_q;
  logic [StkW-1:0]       stk_rdata_q;
  logic [SltW-1:0]       slt_rdata_q;

  logic                  out_valid_q;
  gsa_pkg::out_item_t    out_q;

  logic                  out_free;
  logic                  finish;
  logic                  in_xfer;

  // Write-back of the item held in the registers.
  logic                  stk_we;
  logic [SlotW-1:0]      stk_waddr;
  logic [StkW-1:0]       stk_wdata;
  logic                  slt_we;
  logic [SlotW-1:0]      slt_waddr;
  logic [SltW-1:0]       slt_wdata;

  // Read issue of the item being transferred in.
  logic [TopW-1:0]       pop_next;
  logic [SlotW-1:0]      stk_raddr;
  logic [SlotW-1:0]      slt_raddr;
  logic                  range_ok;

  // Decoded memory words of the item held in the registers.
  logic                  pop_fresh;
  logic [TopW-1:0]       fresh_limit;
  logic [SlotW-1:0]      pop_slot;
  logic [GEN_BITS-1:0]   pop_gen;
  logic                  slot_seen;
  logic [SltW-1:0]       slt_word;
  logic                  slot_mark;
  logic [GEN_BITS-1:0]   slot_gen;
  logic [GEN_BITS-1:0]   gen_inc;
  gsa_pkg::out_item_t    res;

  // An item finishes after its transfer, as soon as the output register is
  // free. A new item may transfer in that same cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign finish     = busy_q && out_free;
  assign in_ready_o = !busy_q || finish;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Finishing item: decode the read data, decide, and build the write-back.
  always_comb begin
    top_d       = top_q;
    min_top_d   = min_top_q;

    pop_fresh   = (top_q == min_top_q);
    if (pop_fresh) begin
      pop_slot = SlotW'(SlotCountT - top_q);
      pop_gen  = '0;
    end else begin
      pop_slot = stk_rdata_q[StkW-1:GEN_BITS];
      pop_gen  = stk_rdata_q[GEN_BITS-1:0];
    end

    fresh_limit = SlotCountT - min_top_q;
    slot_seen   = (TopW'(addr_q) < fresh_limit);
    slt_word    = slot_seen ? slt_rdata_q : '0;
    slot_mark   = slt_word[SltW-1];
    slot_gen    = slt_word[GEN_BITS-1:0];
    gen_inc     = slot_gen + GEN_BITS'(1);

    stk_we      = 1'b0;
    stk_waddr   = top_q[SlotW-1:0];
    stk_wdata   = {addr_q, gen_inc};
    slt_we      = 1'b0;
    slt_waddr   = addr_q;
    slt_wdata   = {1'b0, gen_inc};

    res         = '0;
    res.status  = gsa_pkg::ST_OK;

    if (finish) begin
      case (op_q)
        gsa_pkg::OP_ACQUIRE: begin
          if (top_q == '0) begin
            res.status = gsa_pkg::ST_POOL_EMPTY;
          end else begin
            top_d      = top_q - TopW'(1);
            min_top_d  = (top_d < min_top_q) ? top_d : min_top_q;
            slt_we     = 1'b1;
            slt_waddr  = pop_slot;
            slt_wdata  = {1'b1, pop_gen};
            res.given_slot       = gsa_pkg::GivenSlotW'(pop_slot);
            res.given_generation = gsa_pkg::GivenGenW'(pop_gen);
          end
        end
        gsa_pkg::OP_RELEASE: begin
          if (!range_ok_q) begin
            res.status = gsa_pkg::ST_OUT_OF_RANGE;
          end else if (!slot_mark) begin
            res.status = gsa_pkg::ST_DOUBLE_FREE;
          end else begin
            slt_we = 1'b1;
            if (top_q < SlotCountT) begin
              stk_we = 1'b1;
              top_d  = top_q + TopW'(1);
            end
          end
        end
        gsa_pkg::OP_CHECK: begin
          res.handle_live = range_ok_q && slot_mark &&
                            (CmpW'(slot_gen) == CmpW'(hgen_q));
        end
        default: begin
        end
      endcase
    end

    // The live count always equals the number of slots off the stack.
    res.used_count = gsa_pkg::UsedCountW'(SlotCountT - top_d);
  end

  // Transfer: address the memories with the state that the finishing item
  // leaves behind, so the two items can overlap.
  always_comb begin
    pop_next  = top_d - TopW'(1);
    stk_raddr = pop_next[SlotW-1:0];
    if (in_item_i.op == gsa_pkg::OP_CHECK) begin
      slt_raddr = in_item_i.handle[SlotW-1:0];
      range_ok  = ({1'b0, in_item_i.handle[gsa_pkg::SlotFieldW-1:0]} < SlotCountR);
    end else begin
      slt_raddr = in_item_i.slot[SlotW-1:0];
      range_ok  = ({1'b0, in_item_i.slot} < SlotCountR);
    end
  end

  // Free stack memory. A read that hits the entry written in the same cycle
  // takes the new data.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      if (stk_we && (stk_waddr == stk_raddr)) begin
        stk_rdata_q <= stk_wdata;
      end else begin
        stk_rdata_q <= stk_mem[stk_raddr];
      end
    end
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
  end

  // Slot memory, with the same bypass for a read of the slot being written.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      if (slt_we && (slt_waddr == slt_raddr)) begin
        slt_rdata_q <= slt_wdata;
      end else begin
        slt_rdata_q <= slt_mem[slt_raddr];
      end
    end
    if (slt_we) begin
      slt_mem[slt_waddr] <= slt_wdata;
    end
  end

  // Item fields held until the item finishes.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q       <= in_item_i.op;
      addr_q     <= slt_raddr;
      range_ok_q <= range_ok;
      hgen_q     <= in_item_i.handle[gsa_pkg::HandleW-1:gsa_pkg::SlotFieldW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      top_q       <= SlotCountT;
      min_top_q   <= SlotCountT;
    end else begin
      top_q     <= top_d;
      min_top_q <= min_top_d;
      if (in_xfer) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- verif/gsa_alloc_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the generational slot allocator: watches both channels,
// predicts every result from its own free stack and generation table, and compares.
// Depends on gsa_pkg for the transfer types, opcodes and status codes.
module gsa_alloc_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  gsa_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  gsa_pkg::out_item_t out_item_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int unsigned PoolSize  = 1024;

  logic [gsa_pkg::GivenSlotW-1:0] free_stack_q [PoolSize];
  logic [gsa_pkg::UsedCountW-1:0] free_depth_q;
  logic                           slot_live_q  [PoolSize];
  logic [gsa_pkg::GivenGenW-1:0]  slot_gen_q   [PoolSize];
  logic [gsa_pkg::UsedCountW-1:0] live_total_q;
  gsa_pkg::out_item_t             expected_results [$];
  int                             mismatches = 0;

  assign fail_count_o = mismatches;

  // Applies one operation to the shadow pool and returns the result it should give.
  function automatic gsa_pkg::out_item_t predict_slot_op(input gsa_pkg::in_item_t item);
    gsa_pkg::out_item_t             res;
    logic [gsa_pkg::GivenSlotW-1:0] s;
    logic [gsa_pkg::SlotFieldW-1:0] hs;
    logic [gsa_pkg::HandleGenW-1:0] hg;
    res        = '0;
    res.status = gsa_pkg::ST_OK;
    case (item.op)
      gsa_pkg::OP_ACQUIRE: begin
        if (free_depth_q == 0) begin
          res.status = gsa_pkg::ST_POOL_EMPTY;
        end else begin
          free_depth_q         = free_depth_q - 1'b1;
          s                    = free_stack_q[free_depth_q];
          slot_live_q[s]       = 1'b1;
          live_total_q         = live_total_q + 1'b1;
          res.given_slot       = s;
          res.given_generation = slot_gen_q[s];
        end
      end
      gsa_pkg::OP_RELEASE: begin
        s = item.slot[gsa_pkg::GivenSlotW-1:0];
        if (item.slot >= PoolSize) begin
          res.status = gsa_pkg::ST_OUT_OF_RANGE;
        end else if (!slot_live_q[s]) begin
          res.status = gsa_pkg::ST_DOUBLE_FREE;
        end else begin
          slot_live_q[s] = 1'b0;
          slot_gen_q[s]  = slot_gen_q[s] + 1'b1;
          if (live_total_q != 0) begin
            live_total_q = live_total_q - 1'b1;
          end
          if (free_depth_q < PoolSize) begin
            free_stack_q[free_depth_q] = s;
            free_depth_q               = free_depth_q + 1'b1;
          end
        end
      end
      gsa_pkg::OP_CHECK: begin
        hs = item.handle[gsa_pkg::SlotFieldW-1:0];
        hg = item.handle[gsa_pkg::HandleW-1:gsa_pkg::SlotFieldW];
        s  = hs[gsa_pkg::GivenSlotW-1:0];
        res.handle_live = (hs < PoolSize) && slot_live_q[s] && (slot_gen_q[s] == hg);
      end
      default: begin
      end
    endcase
    res.used_count = live_total_q;
    return res;
  endfunction

  function automatic void report_field(input string field_name,
                                       input longint unsigned want,
                                       input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field_name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gsa_pkg::out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < PoolSize; i++) begin
        free_stack_q[i] = gsa_pkg::GivenSlotW'(PoolSize - 1 - i);
        slot_live_q[i]  = 1'b0;
        slot_gen_q[i]   = '0;
      end
      free_depth_q = gsa_pkg::UsedCountW'(PoolSize);
      live_total_q = '0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result expected none actual %p", $time, out_item_i);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          report_field("given_slot", want.given_slot, out_item_i.given_slot);
          report_field("given_generation", want.given_generation,
                       out_item_i.given_generation);
          report_field("status", want.status, out_item_i.status);
          report_field("handle_live", want.handle_live, out_item_i.handle_live);
          report_field("used_count", want.used_count, out_item_i.used_count);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.insert(expected_results.size(), predict_slot_op(in_item_i));
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Top of the generational slot allocator testbench: clock, reset, stimulus with
// random idling on both channels, and the verdict. Depends on gsa_pkg, the
// generational_slot_allocator block and the gsa_alloc_checker module.
module testbench;

  localparam int unsigned             PoolSize      = 1024;
  localparam logic [gsa_pkg::OpW-1:0] UnusedOpCode  = 2'd3;
  localparam int                      HoldOffCycles = 300;
  localparam int                      HoldOffAt     = 100;
  localparam int                      StallLimit    = 4000;
  localparam int                      DrainCycles   = 10;
  localparam int                      StaleKeep     = 32;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  gsa_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_ready;
  gsa_pkg::out_item_t out_item;
  int                 fail_count;
  int                 pending;

  // Stimulus bookkeeping. The opcode of every transfer into the block is queued so
  // that each result can be matched to its operation; handles handed out by
  // acquires are collected so that releases and checks can target live slots.
  gsa_pkg::op_e                sent_ops      [$];
  logic [gsa_pkg::HandleW-1:0] live_handles  [$];
  logic [gsa_pkg::HandleW-1:0] stale_handles [$];
  int                          pool_empty_seen = 0;
  int                          idle_cycles     = 0;
  int                          sent_count      = 0;
  int                          taken_count     = 0;
  bit                          sender_steady   = 1'b0;
  bit                          receiver_steady = 1'b0;

  always #2 clk = ~clk;

  generational_slot_allocator u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  gsa_alloc_checker u_alloc_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Learn live handles from the results of successful acquires, and count how
  // often the pool was found empty so that the fill phase knows when to stop.
  always @(posedge clk) begin
    gsa_pkg::op_e done_op;
    if (rst_n) begin
      if (out_valid && out_ready && sent_ops.size() != 0) begin
        done_op = sent_ops.pop_front();
        if (done_op == gsa_pkg::OP_ACQUIRE && out_item.status == gsa_pkg::ST_OK) begin
          live_handles.insert(live_handles.size(),
                              {out_item.given_generation,
                               {(gsa_pkg::SlotFieldW - gsa_pkg::GivenSlotW){1'b0}},
                               out_item.given_slot});
        end else if (done_op == gsa_pkg::OP_ACQUIRE &&
                     out_item.status == gsa_pkg::ST_POOL_EMPTY) begin
          pool_empty_seen++;
        end
      end
      if (in_valid && in_ready) begin
        sent_ops.insert(sent_ops.size(), in_item.op);
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count. The longest
  // legal quiet stretch is the receiver's hold-off, well below the limit.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles < StallLimit) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("generational_slot_allocator: mismatch");
      $finish;
    end
  end

  // Receiver. It waits a random number of cycles before taking each result, with
  // stretches of back-to-back transfers, and holds off once for a long time after
  // a fixed number of results so that the block fills up and stops accepting input.
  initial begin
    int stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken_count % 50 == 0) begin
        receiver_steady = ($urandom_range(0, 3) == 0);
      end
      stall = receiver_steady ? 0 : $urandom_range(0, 7);
      if (taken_count == HoldOffAt) begin
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end else if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken_count++;
    end
  end

  function automatic logic [gsa_pkg::SlotFieldW-1:0] random_slot_field();
    return gsa_pkg::SlotFieldW'($urandom());
  endfunction

  function automatic logic [gsa_pkg::HandleW-1:0] random_handle();
    return gsa_pkg::HandleW'({$urandom(), $urandom()});
  endfunction

  function automatic logic [gsa_pkg::HandleW-1:0] pack_handle(
      input logic [gsa_pkg::GivenGenW-1:0]  gen,
      input logic [gsa_pkg::SlotFieldW-1:0] slot);
    return {gen, slot};
  endfunction

  function automatic gsa_pkg::in_item_t make_item(
      input gsa_pkg::op_e                   op,
      input logic [gsa_pkg::SlotFieldW-1:0] slot,
      input logic [gsa_pkg::HandleW-1:0]    handle);
    gsa_pkg::in_item_t item;
    item.op     = op;
    item.slot   = slot;
    item.handle = handle;
    return item;
  endfunction

  // Sender. A random gap of idle cycles comes before each item, except in steady
  // stretches; once raised, valid stays high with the payload held until the
  // transfer happens at an edge where ready is high.
  task automatic offer(input gsa_pkg::in_item_t item);
    int gap;
    if (sent_count % 50 == 0) begin
      sender_steady = ($urandom_range(0, 3) == 0);
    end
    gap = sender_steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // Fields that an operation does not use carry random values, so that every
  // input bit toggles throughout the run.
  task automatic acquire_slot();
    offer(make_item(gsa_pkg::OP_ACQUIRE, random_slot_field(), random_handle()));
  endtask

  task automatic release_slot(input logic [gsa_pkg::SlotFieldW-1:0] slot);
    offer(make_item(gsa_pkg::OP_RELEASE, slot, random_handle()));
  endtask

  task automatic check_handle(input logic [gsa_pkg::HandleW-1:0] handle);
    offer(make_item(gsa_pkg::OP_CHECK, random_slot_field(), handle));
  endtask

  task automatic send_unused_op();
    offer(make_item(gsa_pkg::op_e'(UnusedOpCode), random_slot_field(), random_handle()));
  endtask

  // Releases a slot known to be live. The old handle is kept as a stale one,
  // since its generation no longer matches once the release has gone through.
  task automatic release_live();
    int                          idx;
    logic [gsa_pkg::HandleW-1:0] handle;
    if (live_handles.size() == 0) begin
      release_slot(gsa_pkg::SlotFieldW'($urandom_range(0, 31)));
    end else begin
      idx    = $urandom_range(0, live_handles.size() - 1);
      handle = live_handles[idx];
      live_handles.delete(idx);
      stale_handles.insert(stale_handles.size(), handle);
      if (stale_handles.size() > StaleKeep) begin
        void'(stale_handles.pop_front());
      end
      release_slot(handle[gsa_pkg::SlotFieldW-1:0]);
    end
  endtask

  // Checks a live handle, a stale one, or noise: either a fully random handle
  // or a low slot with a low generation that may happen to match.
  task automatic check_some();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45 && live_handles.size() != 0) begin
      check_handle(live_handles[$urandom_range(0, live_handles.size() - 1)]);
    end else if (pick < 70 && stale_handles.size() != 0) begin
      check_handle(stale_handles[$urandom_range(0, stale_handles.size() - 1)]);
    end else if (pick < 85) begin
      check_handle(pack_handle($urandom_range(0, 3),
                               gsa_pkg::SlotFieldW'($urandom_range(0, 31))));
    end else begin
      check_handle(random_handle());
    end
  endtask

  // One item of the mixed phase: a small working set of slots that is acquired,
  // released, checked and occasionally hit with bad releases or the unused opcode.
  task automatic mixed_item();
    int pick;
    int sub;
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 99);
    if (pick < 38) begin
      acquire_slot();
    end else if (pick < 68) begin
      if (sub < 65) begin
        release_live();
      end else if (sub < 85) begin
        release_slot(gsa_pkg::SlotFieldW'($urandom_range(0, 31)));
      end else begin
        release_slot(gsa_pkg::SlotFieldW'($urandom_range(PoolSize,
                                                         (1 << gsa_pkg::SlotFieldW) - 1)));
      end
    end else if (pick < 97) begin
      check_some();
    end else begin
      send_unused_op();
    end
  endtask

  // Stops offering until every result in flight has come out of the block.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Directed opening: the corners of each operation on a freshly reset pool,
  // including reuse of the most recently released slot with a bumped generation.
  task automatic run_directed();
    check_handle(pack_handle(0, 0));                       // never allocated
    release_slot(0);                                       // free of an unallocated slot
    release_slot('1);                                      // highest slot field value
    release_slot(gsa_pkg::SlotFieldW'(PoolSize));          // first slot past the pool
    release_slot(gsa_pkg::SlotFieldW'(PoolSize - 1));      // last slot, not allocated
    acquire_slot();                                        // slot 0, generation 0
    check_handle(pack_handle(0, 0));                       // live
    check_handle(pack_handle(1, 0));                       // wrong generation
    check_handle('1);                                      // slot field out of range
    check_handle(pack_handle(0, gsa_pkg::SlotFieldW'(PoolSize - 1)));
    check_handle(pack_handle(0, gsa_pkg::SlotFieldW'(PoolSize)));
    acquire_slot();                                        // slot 1
    release_slot(0);                                       // generation of slot 0 now 1
    check_handle(pack_handle(0, 0));                       // stale after release
    release_slot(0);                                       // double free
    acquire_slot();                                        // slot 0 comes back first
    check_handle(pack_handle(1, 0));
    check_handle(pack_handle('1, 0));                      // highest generation
    send_unused_op();
    release_slot(1);
    release_slot(0);
    acquire_slot();                                        // slot 0, generation 2
    acquire_slot();                                        // slot 1, generation 1
    check_handle(pack_handle(1, 1));
  endtask

  initial begin
    int n;
    int pick;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    // Mixed traffic on a small working set. Early on, the receiver holds off so
    // the input backs up; later the sender waits for a full drain.
    for (n = 0; n < 250; n++) begin
      if (n == 170) begin
        wait_drained();
      end
      mixed_item();
    end
    wait_drained();

    // Fill the pool until acquires are refused several times, with a few checks
    // in between. The upper bound keeps a broken block from looping forever.
    n = 0;
    while ((n < 1000 || pool_empty_seen < 24) && n < 1300) begin
      if ($urandom_range(0, 99) < 97) begin
        acquire_slot();
      end else begin
        check_some();
      end
      n++;
    end

    // Churn near a full pool: released slots are handed out again at once with
    // their bumped generations.
    for (n = 0; n < 120; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        release_live();
      end else if (pick < 90) begin
        acquire_slot();
      end else begin
        check_some();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("generational_slot_allocator: match");
    end else begin
      $display("generational_slot_allocator: mismatch");
    end
    $finish;
  end

endmodule

// ----- generational_slot_allocator.f -----
rtl/core/gsa_pkg.sv
rtl/core/generational_slot_allocator.sv
verif/gsa_alloc_checker.sv
verif/testbench.sv
